// ===== sv/bop_pkg.sv =====
package bop_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned TagW         = 24;
  localparam int unsigned WordAddrW    = 30;

  localparam logic [6:0]  BranchOpcode = 7'd99;
  localparam logic [31:0] CountMax     = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ModeTaken    = 2'd0,
    ModeNotTaken = 2'd1,
    ModeOneBit   = 2'd2,
    ModeTwoBit   = 2'd3
  } mode_e;

  localparam mode_e ModeReset = ModeTwoBit;

  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] instr_word;
    logic [31:0] next_pc;
    logic        trace_end;
  } bop_in_t;

  typedef struct packed {
    logic [31:0] branch_pc;
    logic [31:0] target_pc;
    logic        actual_taken;
    logic        predicted_taken;
    logic        hit_correct;
    logic [31:0] branches_seen;
    logic [31:0] correct_seen;
  } bop_out_t;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [1:0]      state;
  } tbl_entry_t;

  typedef struct packed {
    logic       valid;
    tbl_entry_t entry;
  } lookup_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] idx;
    tbl_entry_t      entry;
  } update_t;

  typedef struct packed {
    logic        is_branch;
    logic [31:0] target;
    logic        actual;
    logic        pred;
    logic        correct;
  } decide_t;

  function automatic logic [IdxW-1:0] entry_idx(input logic [31:0] pc);
    logic [WordAddrW-1:0] wa;
    wa = pc[31:2];
    return wa[IdxW-1:0];
  endfunction

  function automatic logic [TagW-1:0] entry_tag(input logic [31:0] pc);
    logic [WordAddrW-1:0] wa;
    wa = pc[31:2];
    return TagW'(wa >> IdxW);
  endfunction

  // B-type immediate, sign-extended from bit 12.
  function automatic logic [31:0] branch_offset(input logic [31:0] w);
    return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  endfunction

endpackage

// ===== sv/bop_table.sv =====
module bop_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              rd_en_i,
  input  logic [bop_pkg::IdxW-1:0] rd_idx_i,
  input  logic [bop_pkg::IdxW-1:0] lk_idx_i,
  input  bop_pkg::update_t  upd_i,
  output bop_pkg::lookup_t  lookup_o
);
  import bop_pkg::*;

  tbl_entry_t           mem [TableEntries];
  tbl_entry_t           rd_q;
  tbl_entry_t           fwd_entry_q;
  logic                 fwd_q;
  logic [TableEntries-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (upd_i.we) begin
      mem[upd_i.idx] <= upd_i.entry;
    end
    if (rd_en_i) begin
      rd_q        <= mem[rd_idx_i];
      fwd_entry_q <= upd_i.entry;
    end
  end

  // The entry written at the same edge as this read is forwarded, since the
  // memory returns the old contents in that case.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= upd_i.we && (upd_i.idx == rd_idx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (upd_i.we) begin
      valid_q[upd_i.idx] <= 1'b1;
    end
  end

  always_comb begin
    lookup_o.valid = valid_q[lk_idx_i];
    lookup_o.entry = fwd_q ? fwd_entry_q : rd_q;
  end

endmodule

// ===== sv/bop_decide.sv =====
module bop_decide (
  input  bop_pkg::bop_in_t  item_i,
  input  bop_pkg::mode_e    mode_i,
  input  bop_pkg::lookup_t  lookup_i,
  output bop_pkg::decide_t  dec_o,
  output bop_pkg::update_t  upd_o
);
  import bop_pkg::*;

  logic [TagW-1:0] tag;
  logic            miss;
  logic [1:0]      init_state;
  logic [1:0]      cur_state;
  logic [1:0]      next_state;
  logic [31:0]     target;
  logic            actual;
  logic            pred;

  always_comb begin
    tag        = entry_tag(item_i.pc);
    miss       = !lookup_i.valid || (lookup_i.entry.tag != tag);
    init_state = (mode_i == ModeTaken || mode_i == ModeTwoBit) ? 2'd1 : 2'd0;
    cur_state  = miss ? init_state : lookup_i.entry.state;
    target     = item_i.pc + branch_offset(item_i.instr_word);
    actual     = !item_i.trace_end && (item_i.next_pc == target);

    case (mode_i)
      ModeTaken: begin
        pred       = 1'b1;
        next_state = cur_state;
      end
      ModeNotTaken: begin
        pred       = 1'b0;
        next_state = cur_state;
      end
      ModeOneBit: begin
        pred       = cur_state[0];
        next_state = {1'b0, actual};
      end
      ModeTwoBit: begin
        pred = cur_state[1];
        if (actual) begin
          next_state = (cur_state == 2'd3) ? cur_state : cur_state + 2'd1;
        end else begin
          next_state = (cur_state == 2'd0) ? cur_state : cur_state - 2'd1;
        end
      end
      default: begin
        pred       = 1'b0;
        next_state = cur_state;
      end
    endcase

    dec_o.is_branch = (item_i.instr_word[6:0] == BranchOpcode);
    dec_o.target    = target;
    dec_o.actual    = actual;
    dec_o.pred      = pred;
    dec_o.correct   = (pred == actual);

    upd_o.we          = dec_o.is_branch;
    upd_o.idx         = entry_idx(item_i.pc);
    upd_o.entry.tag   = tag;
    upd_o.entry.state = next_state;
  end

endmodule

// ===== sv/branch_outcome_predictor_core.sv =====
// An accepted item enters in_q as its table entry is read; a branch then
// registers its result in res_o. Throughput: one item per cycle; the table
// read-modify-write forwards an entry written at an edge to the item read there.
// Reset (async, active low) clears all valid bits and both totals and sets
// the two-bit mode; a mode write clears the same state. busy stays low.
module branch_outcome_predictor_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bop_pkg::bop_in_t  item_i,
  output logic              res_valid_o,
  output bop_pkg::bop_out_t res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_data_i
);
  import bop_pkg::*;

  logic        accept;
  logic        cfg_accept;
  mode_e       mode_q;
  bop_in_t     in_q;
  logic        in_valid_q;
  lookup_t     lookup;
  decide_t     dec;
  update_t     dec_upd;
  update_t     upd;
  logic [31:0] branch_total_q, branch_total_d;
  logic [31:0] correct_total_q, correct_total_d;
  logic        fire;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeReset;
    end else if (cfg_accept) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= item_i;
    end
  end

  bop_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (cfg_accept),
    .rd_en_i  (accept),
    .rd_idx_i (entry_idx(item_i.pc)),
    .lk_idx_i (entry_idx(in_q.pc)),
    .upd_i    (upd),
    .lookup_o (lookup)
  );

  bop_decide u_decide (
    .item_i   (in_q),
    .mode_i   (mode_q),
    .lookup_i (lookup),
    .dec_o    (dec),
    .upd_o    (dec_upd)
  );

  assign fire = in_valid_q && dec.is_branch;

  always_comb begin
    upd    = dec_upd;
    upd.we = fire;
  end

  always_comb begin
    branch_total_d  = (branch_total_q == CountMax) ? branch_total_q
                                                   : branch_total_q + 32'd1;
    correct_total_d = correct_total_q;
    if (dec.correct && correct_total_q != CountMax) begin
      correct_total_d = correct_total_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      branch_total_q  <= '0;
      correct_total_q <= '0;
    end else if (cfg_accept) begin
      branch_total_q  <= '0;
      correct_total_q <= '0;
    end else if (fire) begin
      branch_total_q  <= branch_total_d;
      correct_total_q <= correct_total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_o.branch_pc       <= in_q.pc;
      res_o.target_pc       <= dec.target;
      res_o.actual_taken    <= dec.actual;
      res_o.predicted_taken <= dec.pred;
      res_o.hit_correct     <= dec.correct;
      res_o.branches_seen   <= branch_total_d;
      res_o.correct_seen    <= correct_total_d;
    end
  end

  a_res_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(in_valid_q))
    else $error("result beat without an item in the stage");

  a_cfg_clears_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_accept |=> (branch_total_q == '0) && (correct_total_q == '0))
    else $error("totals not cleared by a mode write");

  a_correct_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    correct_total_q <= branch_total_q)
    else $error("correct count exceeds branch count");

endmodule

// ===== tb/bop_ledger_pkg.sv =====
`timescale 1ns / 1ps

package bop_ledger_pkg;
  import bop_pkg::*;

  // Tracks the predictor table and totals, and keeps the branch reports still owed by the core.
  class branch_ledger;
    mode_e           mode;
    logic [1:0]      ctr [TableEntries];
    bit              live [TableEntries];
    logic [TagW-1:0] owner [TableEntries];
    logic [31:0]     branch_count;
    logic [31:0]     hit_count;
    bop_out_t        awaited [$];
    int unsigned     mismatches;

    function new();
      mode = ModeReset;
      foreach (ctr[i]) begin
        ctr[i] = 2'd0;
        live[i] = 1'b0;
        owner[i] = '0;
      end
      branch_count = '0;
      hit_count = '0;
      mismatches = 0;
    endfunction

    // A mode write flushes the table and both totals.
    function void set_mode(mode_e m);
      mode = m;
      foreach (live[i]) live[i] = 1'b0;
      branch_count = '0;
      hit_count = '0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void note_instr(bop_in_t it);
      logic [12:0]     imm;
      logic [31:0]     target;
      logic [31:0]     waddr;
      int unsigned     slot;
      logic [TagW-1:0] key;
      logic            taken;
      logic            guess;
      bop_out_t        rep;
      if (it.instr_word[6:0] != BranchOpcode) return;
      imm = {it.instr_word[31], it.instr_word[7], it.instr_word[30:25],
             it.instr_word[11:8], 1'b0};
      target = it.pc + {{19{imm[12]}}, imm};
      taken = !it.trace_end && (it.next_pc == target);
      waddr = it.pc >> 2;
      slot = waddr % TableEntries;
      key = TagW'(waddr / TableEntries);
      if (!live[slot] || owner[slot] != key) begin
        live[slot] = 1'b1;
        owner[slot] = key;
        // A fresh entry starts at 1 (weakly not-taken in two-bit mode) only in the always-taken and two-bit modes.
        ctr[slot] = (mode == ModeTaken || mode == ModeTwoBit) ? 2'd1 : 2'd0;
      end
      case (mode)
        ModeTaken: guess = 1'b1;
        ModeNotTaken: guess = 1'b0;
        ModeOneBit: begin
          guess = ctr[slot][0];
          ctr[slot] = {1'b0, taken};
        end
        default: begin
          guess = ctr[slot][1];
          if (taken && ctr[slot] != 2'd3) ctr[slot] = ctr[slot] + 2'd1;
          else if (!taken && ctr[slot] != 2'd0) ctr[slot] = ctr[slot] - 2'd1;
        end
      endcase
      if (branch_count != CountMax) branch_count = branch_count + 1;
      if (guess == taken && hit_count != CountMax) hit_count = hit_count + 1;
      rep.branch_pc = it.pc;
      rep.target_pc = target;
      rep.actual_taken = taken;
      rep.predicted_taken = guess;
      rep.hit_correct = (guess == taken);
      rep.branches_seen = branch_count;
      rep.correct_seen = hit_count;
      awaited.insert(awaited.size(), rep);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %h, actual %h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(bop_out_t got);
      bop_out_t want;
      if (awaited.size() == 0) begin
        $error("branch report for pc %h arrived with none outstanding", got.branch_pc);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare("branch_pc", want.branch_pc, got.branch_pc);
      compare("target_pc", want.target_pc, got.target_pc);
      compare("actual_taken", 32'(want.actual_taken), 32'(got.actual_taken));
      compare("predicted_taken", 32'(want.predicted_taken), 32'(got.predicted_taken));
      compare("hit_correct", 32'(want.hit_correct), 32'(got.hit_correct));
      compare("branches_seen", want.branches_seen, got.branches_seen);
      compare("correct_seen", want.correct_seen, got.correct_seen);
    endfunction
  endclass

endpackage

// ===== tb/branch_outcome_predictor_core_test.sv =====
`timescale 1ns / 1ps

module branch_outcome_predictor_core_test;
  import bop_pkg::*;
  import bop_ledger_pkg::*;

  localparam int unsigned CycleLimit       = 200000;
  localparam int unsigned PoolSize         = 12;
  localparam int unsigned BranchesPerPhase = 140;
  localparam int unsigned NumPhases        = 8;
  localparam logic [31:0] LoopPc           = 32'h8000_1000;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  bop_in_t    item_i;
  logic       res_valid_o;
  bop_out_t   res_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i;

  branch_ledger ledger = new();
  int unsigned  cycle_count = 0;

  // Hot branches revisited during a phase, so that entries hit and counters saturate.
  logic [31:0] pool_pc [PoolSize];
  logic [12:0] pool_imm [PoolSize];
  int unsigned pool_bias [PoolSize];

  mode_e       phase_mode [NumPhases] = '{ModeTaken, ModeNotTaken, ModeOneBit, ModeTwoBit,
                                          ModeOneBit, ModeTaken, ModeTwoBit, ModeNotTaken};
  int unsigned phase_idle [NumPhases] = '{0, 61, 11, 0, 61, 11, 30, 61};

  branch_outcome_predictor_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (res_valid_o === 1'b1) ledger.check_report(res_o);
      if (cfg_valid_i && cfg_ready_o === 1'b1) ledger.set_mode(mode_e'(cfg_data_i));
      if (start && busy === 1'b0) ledger.note_instr(item_i);
    end
  end

  function automatic bop_in_t make_branch(logic [31:0] pc, logic [12:0] imm, bit taken,
                                          bit last);
    bop_in_t     it;
    logic [31:0] junk;
    junk = $urandom;
    it.pc = pc;
    it.instr_word = {imm[12], imm[10:5], junk[24:12], imm[4:1], imm[11], BranchOpcode};
    if (taken) it.next_pc = pc + {{19{imm[12]}}, imm};
    else if ($urandom_range(0, 1) == 1) it.next_pc = pc + 32'd4;
    else it.next_pc = $urandom;
    it.trace_end = last;
    return it;
  endfunction

  function automatic bop_in_t random_item();
    bop_in_t     it;
    int unsigned k;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      it = {$urandom, $urandom, $urandom, 1'($urandom)};
    end else if (roll < 25) begin
      it = make_branch($urandom, {12'($urandom), 1'b0}, $urandom_range(0, 1) == 1,
                       $urandom_range(0, 19) == 0);
    end else begin
      k = $urandom_range(0, PoolSize - 1);
      it = make_branch(pool_pc[k], pool_imm[k], $urandom_range(0, 99) < pool_bias[k],
                       $urandom_range(0, 49) == 0);
    end
    return it;
  endfunction

  // Some pool entries share an index with the previous one under another tag, others
  // differ from it only in the two low pc bits and so map to the same entry.
  task automatic refill_pool();
    for (int k = 0; k < PoolSize; k++) begin
      case ((k == 0) ? 5 : $urandom_range(0, 5))
        0: pool_pc[k] = pool_pc[k-1] + ($urandom_range(1, 255) << 8);
        1: pool_pc[k] = pool_pc[k-1] ^ 32'($urandom_range(1, 3));
        default: pool_pc[k] = $urandom;
      endcase
      pool_imm[k] = {12'($urandom), 1'b0};
      case ($urandom_range(0, 4))
        0: pool_bias[k] = 0;
        1: pool_bias[k] = 5;
        2: pool_bias[k] = 50;
        3: pool_bias[k] = 95;
        default: pool_bias[k] = 100;
      endcase
    end
  endtask

  task automatic send(bop_in_t it);
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Each cycle stays idle with the given percent chance; junk rides on the bus meanwhile.
  task automatic maybe_idle(int unsigned pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      item_i <= {$urandom, $urandom, $urandom, 1'($urandom)};
      @(posedge clk_i);
    end
  endtask

  // Non-branch items still in flight produce nothing, so keep waiting after the last report.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(mode_e m);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_directed();
    send(bop_in_t'{pc: 32'h0, instr_word: 32'h0, next_pc: 32'h0, trace_end: 1'b0});
    send(bop_in_t'{pc: 32'hFFFF_FFFF, instr_word: 32'hFFFF_FFFF, next_pc: 32'hFFFF_FFFF,
                   trace_end: 1'b1});
    // One bit away from the branch opcode.
    send(bop_in_t'{pc: 32'h40, instr_word: {25'h1FF_FFFF, 7'h62}, next_pc: 32'h44,
                   trace_end: 1'b0});
    send(make_branch(32'h0, 13'h0FFE, 1'b1, 1'b0));
    send(make_branch(32'hFFFF_FFFC, 13'h1000, 1'b1, 1'b0));
    send(make_branch(32'hFFFF_FFF0, 13'h0010, 1'b1, 1'b0));
    send(make_branch(32'h0000_0100, 13'h1000, 1'b0, 1'b0));
    // At the end of the trace the branch is not taken even though next_pc hits the target.
    send(make_branch(32'h0000_2000, 13'h0020, 1'b1, 1'b1));
    for (int n = 0; n < 8; n++) send(make_branch(LoopPc, 13'h1FF8, n < 4, 1'b0));
    send(make_branch(LoopPc | 32'h3, 13'h1FF8, 1'b1, 1'b0));
    send(make_branch(LoopPc + 32'h100, 13'h1FF8, 1'b1, 1'b0));
    send(make_branch(LoopPc, 13'h1FF8, 1'b1, 1'b0));
    send(bop_in_t'{pc: 32'h1234_5678, instr_word: 32'hFFFF_FFE3, next_pc: 32'h1234_5676,
                   trace_end: 1'b0});
  endtask

  initial begin
    bop_in_t     it;
    int unsigned branches;
    bit          paused;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = ModeReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    settle();

    for (int p = 0; p < NumPhases; p++) begin
      write_mode(phase_mode[p]);
      refill_pool();
      branches = 0;
      paused = 1'b0;
      while (branches < BranchesPerPhase) begin
        it = random_item();
        send(it);
        if (it.instr_word[6:0] == BranchOpcode) branches++;
        if (!paused && branches == BranchesPerPhase / 2) begin
          paused = 1'b1;
          settle();
        end else begin
          maybe_idle(phase_idle[p]);
        end
      end
      settle();
    end

    repeat (4) @(posedge clk_i);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bop_pkg.sv
sv/bop_table.sv
sv/bop_decide.sv
sv/branch_outcome_predictor_core.sv
tb/bop_ledger_pkg.sv
tb/branch_outcome_predictor_core_test.sv
